// File: hdl/ikpm_pkg.sv
// ============================================================================
// ikpm_pkg
// Shared constants, codes and types of the iambic keyer with paddle memory.
// ============================================================================
package ikpm_pkg;

    // Longest dot unit in ticks. A larger register value saturates to it.
    localparam int MAX_UNIT_TICKS = 240;
    localparam int DASH_UNITS     = 3;

    localparam int UNIT_W  = 8;
    localparam int TICKS_W = $clog2(DASH_UNITS * MAX_UNIT_TICKS);
    localparam int PHASE_W = 2;
    localparam int ELEM_W  = 2;

    localparam logic [UNIT_W-1:0] UNIT_RESET = UNIT_W'(60);

    localparam logic [PHASE_W-1:0] PHASE_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_MARK  = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_SPACE = 2'd2;

    localparam logic [ELEM_W-1:0] ELEM_NONE = 2'd0;
    localparam logic [ELEM_W-1:0] ELEM_DOT  = 2'd1;
    localparam logic [ELEM_W-1:0] ELEM_DASH = 2'd2;

    typedef logic [UNIT_W-1:0]  unit_t;
    typedef logic [TICKS_W-1:0] ticks_t;
    typedef logic [ELEM_W-1:0]  elem_t;

    // Counter load values for the next phase: length minus one.
    typedef struct packed {
        ticks_t dot_load;
        ticks_t dash_load;
    } load_t;

    // One result beat.
    typedef struct packed {
        logic  key_on;
        elem_t element_started;
    } result_t;

endpackage

// File: hdl/ikpm_if.sv
// ============================================================================
// ikpm_if
// Valid/ready channels of the keyer: paddle input, key result, unit setting.
// ============================================================================
interface ikpm_paddle_if;
    logic valid;
    logic ready;
    logic dot_paddle_pressed;
    logic dash_paddle_pressed;

    modport source (output valid, output dot_paddle_pressed, output dash_paddle_pressed,
                    input ready);
    modport sink   (input valid, input dot_paddle_pressed, input dash_paddle_pressed,
                    output ready);
endinterface

interface ikpm_key_if;
    logic                      valid;
    logic                      ready;
    logic                      key_on;
    logic [ikpm_pkg::ELEM_W-1:0] element_started;

    modport source (output valid, output key_on, output element_started, input ready);
    modport sink   (input valid, input key_on, input element_started, output ready);
endinterface

interface ikpm_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [ikpm_pkg::UNIT_W-1:0] dot_unit_ticks;

    modport source (output valid, output dot_unit_ticks, input ready);
    modport sink   (input valid, input dot_unit_ticks, output ready);
endinterface

// File: hdl/ikpm_unit_len.sv
// ============================================================================
// ikpm_unit_len
// Holds the dot unit setting and derives the mark and space counter loads.
// ============================================================================
module ikpm_unit_len
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  ikpm_pkg::unit_t      wr_data,
    output ikpm_pkg::load_t      loads
);

    ikpm_pkg::unit_t  unit_reg;
    ikpm_pkg::ticks_t unit_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg <= ikpm_pkg::UNIT_RESET;
        end
        else if (wr_en)
        begin
            unit_reg <= wr_data;
        end
    end

    // A zero unit counts as one tick; a long one saturates.
    always_comb
    begin
        unit_len = ikpm_pkg::TICKS_W'(unit_reg);
        if (unit_reg == '0)
        begin
            unit_len = ikpm_pkg::TICKS_W'(1);
        end
        else if (unit_len > ikpm_pkg::TICKS_W'(ikpm_pkg::MAX_UNIT_TICKS))
        begin
            unit_len = ikpm_pkg::TICKS_W'(ikpm_pkg::MAX_UNIT_TICKS);
        end
    end

    assign loads.dot_load  = unit_len - ikpm_pkg::TICKS_W'(1);
    assign loads.dash_load = (unit_len << 1) + unit_len - ikpm_pkg::TICKS_W'(1);

endmodule

// File: hdl/ikpm_fsm.sv
// ============================================================================
// ikpm_fsm
// Keyer state: paddle latches, last element, phase and tick down counter.
// ============================================================================
module ikpm_fsm
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 dot_in,
    input  logic                 dash_in,
    input  ikpm_pkg::load_t      loads,
    output ikpm_pkg::result_t    result
);

    logic                            dot_mem_reg,  dot_mem_next;
    logic                            dash_mem_reg, dash_mem_next;
    logic                            prev_dot_reg, prev_dot_next;
    logic                            cur_dash_reg, cur_dash_next;
    logic [ikpm_pkg::PHASE_W-1:0]    phase_reg,    phase_next;
    ikpm_pkg::ticks_t                ticks_reg,    ticks_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_mem_reg  <= 1'b0;
            dash_mem_reg <= 1'b0;
            prev_dot_reg <= 1'b0;
            cur_dash_reg <= 1'b0;
            phase_reg    <= ikpm_pkg::PHASE_IDLE;
            ticks_reg    <= '0;
        end
        else if (step)
        begin
            dot_mem_reg  <= dot_mem_next;
            dash_mem_reg <= dash_mem_next;
            prev_dot_reg <= prev_dot_next;
            cur_dash_reg <= cur_dash_next;
            phase_reg    <= phase_next;
            ticks_reg    <= ticks_next;
        end
    end

    always_comb
    begin
        logic do_idle;
        logic send_dash;

        dot_mem_next  = dot_mem_reg;
        dash_mem_next = dash_mem_reg;
        prev_dot_next = prev_dot_reg;
        cur_dash_next = cur_dash_reg;
        phase_next    = phase_reg;
        ticks_next    = ticks_reg;
        result.key_on          = 1'b0;
        result.element_started = ikpm_pkg::ELEM_NONE;
        do_idle   = 1'b0;
        send_dash = 1'b0;

        // During mark and space the paddle opposite the current element is latched.
        if (phase_reg == ikpm_pkg::PHASE_MARK || phase_reg == ikpm_pkg::PHASE_SPACE)
        begin
            if (cur_dash_reg)
            begin
                dot_mem_next = dot_mem_reg | dot_in;
            end
            else
            begin
                dash_mem_next = dash_mem_reg | dash_in;
            end
        end

        unique case (phase_reg)
            ikpm_pkg::PHASE_MARK:
            begin
                if (ticks_reg == '0)
                begin
                    phase_next = ikpm_pkg::PHASE_SPACE;
                    ticks_next = loads.dot_load;
                end
                else
                begin
                    ticks_next    = ticks_reg - ikpm_pkg::TICKS_W'(1);
                    result.key_on = 1'b1;
                end
            end
            ikpm_pkg::PHASE_SPACE:
            begin
                if (ticks_reg == '0)
                begin
                    do_idle = 1'b1;
                end
                else
                begin
                    ticks_next = ticks_reg - ikpm_pkg::TICKS_W'(1);
                end
            end
            default:
            begin
                // Idle, and the unused phase code behaves the same way.
                do_idle = 1'b1;
            end
        endcase

        if (do_idle)
        begin
            dot_mem_next  = dot_mem_next | dot_in;
            dash_mem_next = dash_mem_next | dash_in;
            // Both latched: alternate against the last element sent.
            send_dash = (dot_mem_next && dash_mem_next) ? prev_dot_reg : dash_mem_next;
            if (dot_mem_next || dash_mem_next)
            begin
                cur_dash_next = send_dash;
                prev_dot_next = !send_dash;
                phase_next    = ikpm_pkg::PHASE_MARK;
                result.key_on = 1'b1;
                if (send_dash)
                begin
                    dash_mem_next          = 1'b0;
                    ticks_next             = loads.dash_load;
                    result.element_started = ikpm_pkg::ELEM_DASH;
                end
                else
                begin
                    dot_mem_next           = 1'b0;
                    ticks_next             = loads.dot_load;
                    result.element_started = ikpm_pkg::ELEM_DOT;
                end
            end
            else
            begin
                phase_next = ikpm_pkg::PHASE_IDLE;
            end
        end
    end

endmodule

// File: hdl/iambic_keyer_with_paddle_memory.sv
// ============================================================================
// iambic_keyer_with_paddle_memory
// Iambic Morse keyer with paddle memory, one paddle beat per tick.
// ============================================================================
//
//  Channel  Direction  Payload                               Handshake
//  -------  ---------  ------------------------------------  -----------
//  paddle   in         dot_paddle_pressed, dash_paddle_pressed valid/ready
//  key      out        key_on, element_started               valid/ready
//  cfg      in         dot_unit_ticks                        valid/ready
//
//  Every paddle beat gives exactly one key beat, via the input and result registers.
//  A new paddle beat is taken in every cycle while the key side drains; the
//  rate is one beat per cycle, set by the single state update in ikpm_fsm.
//  A stall on the key side holds the result register, then the input
//  register, and only then drops paddle.ready.
//  Reset (rst_n low, asynchronous) empties both registers, clears the keyer
//  state to idle and loads a dot unit of 60 ticks. cfg is always ready.
//
module iambic_keyer_with_paddle_memory
(
    input  logic              clk,
    input  logic              rst_n,
    ikpm_paddle_if.sink       paddle,
    ikpm_key_if.source        key,
    ikpm_cfg_if.sink          cfg
);

    // Input register: one paddle beat waiting for the state update.
    logic              in_valid_reg;
    logic              in_dot_reg;
    logic              in_dash_reg;

    // Result register: one key beat waiting for the sink.
    logic              out_valid_reg;
    ikpm_pkg::result_t out_result_reg;

    logic              out_free;
    logic              step;
    ikpm_pkg::load_t   loads;
    ikpm_pkg::result_t result;

    // The result register can take a new beat when it is empty or being
    // drained this cycle. The state advances exactly when a held paddle beat
    // moves into it, so beats are processed in order, once each.
    assign out_free     = !out_valid_reg || key.ready;
    assign step         = in_valid_reg && out_free;
    assign paddle.ready = !in_valid_reg || out_free;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (paddle.ready)
        begin
            in_valid_reg <= paddle.valid;
        end
    end

    // Payload needs no reset; it is only looked at when the valid bit is set.
    always_ff @(posedge clk)
    begin
        if (paddle.ready && paddle.valid)
        begin
            in_dot_reg  <= paddle.dot_paddle_pressed;
            in_dash_reg <= paddle.dash_paddle_pressed;
        end
    end

    // The unit setting and the counter loads derived from it.
    ikpm_unit_len u_unit_len
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg.valid && cfg.ready),
        .wr_data (cfg.dot_unit_ticks),
        .loads   (loads)
    );

    // Keyer state machine: one tick of the keyer per step.
    ikpm_fsm u_fsm
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .dot_in  (in_dot_reg),
        .dash_in (in_dash_reg),
        .loads   (loads),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_result_reg <= result;
        end
    end

    assign key.valid           = out_valid_reg;
    assign key.key_on          = out_result_reg.key_on;
    assign key.element_started = out_result_reg.element_started;

    // An element only starts on a keyed tick.
    a_start_keys: assert property (@(posedge clk) disable iff (!rst_n)
        (key.valid && key.element_started != ikpm_pkg::ELEM_NONE) |-> key.key_on)
        else $error("element start without key_on");

    // The start marker only carries a defined element code.
    a_start_code: assert property (@(posedge clk) disable iff (!rst_n)
        key.valid |-> (key.element_started == ikpm_pkg::ELEM_NONE ||
                       key.element_started == ikpm_pkg::ELEM_DOT ||
                       key.element_started == ikpm_pkg::ELEM_DASH))
        else $error("undefined element code");

    // Backpressure reaches the paddle side only through a stalled result.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !paddle.ready |-> (key.valid && !key.ready))
        else $error("paddle stalled without a stalled result");

    // A held paddle beat with room downstream always produces a result beat.
    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_free) |=> key.valid)
        else $error("processed beat did not reach the result register");

endmodule
